[rtl/sm4g_pkg.sv]
package sm4g_pkg;

  // item kinds as they arrive on the input queue
  typedef enum logic [1:0] {
    KIND_AAD  = 2'd0,
    KIND_TEXT = 2'd1,
    KIND_FIN  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY_HIGH   = 3'd0,
    CFG_KEY_LOW    = 3'd1,
    CFG_NONCE_HIGH = 3'd2,
    CFG_NONCE_LOW  = 3'd3,
    CFG_DECRYPT    = 3'd4
  } cfg_idx_e;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned Rounds     = 32;
  localparam logic [4:0]  FullBytes  = 5'd16;
  localparam logic [31:0] CtrStart   = 32'd2;
  localparam logic [31:0] CtrTag     = 32'd1;
  localparam logic [7:0]  GfPoly     = 8'hE1;

  localparam logic [31:0] FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  valid_bytes;
  } sm4g_in_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  out_bytes;
    logic        is_tag;
    logic        tag_match;
  } sm4g_out_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_e        kind;
    logic [127:0] data;
    logic [4:0]   nbytes;
  } sm4g_item_t;

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    sub_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

  // key schedule constant: byte j of word i is (4i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input logic [4:0] i);
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    ck_word = {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7),
               8'((base + 8'd2) * 8'd7), 8'((base + 8'd3) * 8'd7)};
  endfunction

  // keep the first n bytes, byte 0 in the top bits
  function automatic logic [127:0] byte_mask(input logic [4:0] n);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < BlockBytes; b++) begin
      if (5'(b) < n) m[127 - 8*b -: 8] = 8'hff;
    end
    byte_mask = m;
  endfunction

endpackage

[rtl/sm4g_front.sv]
module sm4g_front import sm4g_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  sm4g_in_t   in_data_i,
  output logic       item_valid_o,
  output sm4g_item_t item_o,
  input  logic       item_pop_i
);

  sm4g_item_t fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en, accept;
  logic [4:0] n_norm;
  sm4g_item_t item_in;

  assign full   = (cnt_q == 2'd2);
  assign accept = push && !full;

  // normalize byte count and mask the unused bytes; FIN data passes unmasked
  always_comb begin
    n_norm = (in_data_i.valid_bytes == 5'd0 || in_data_i.valid_bytes > FullBytes)
             ? FullBytes : in_data_i.valid_bytes;
    item_in.kind   = kind_e'(in_data_i.kind);
    item_in.nbytes = n_norm;
    if (item_in.kind == KIND_FIN) begin
      item_in.data = {in_data_i.data_high, in_data_i.data_low};
    end else begin
      item_in.data = {in_data_i.data_high, in_data_i.data_low} & byte_mask(n_norm);
    end
  end

  // drop the unused kind code at the door
  assign wr_en = accept && (item_in.kind != KIND_NONE);
  assign rd_en = item_pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // store the beat
  always_ff @(posedge clk_i) begin
    if (wr_en) fifo_q[wr_ptr_q] <= item_in;
  end

  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];

endmodule

[rtl/sm4g_ghash.sv]
module sm4g_ghash import sm4g_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] block_i,
  input  logic [127:0] h_i,
  input  logic         clear_i,
  output logic [127:0] acc_o,
  output logic         busy_o
);

  logic [127:0] acc_q, acc_d, x_q, x_d, z_q, z_d, v_q, v_d;
  logic [4:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;

  // four multiply steps per cycle while busy
  always_comb begin
    logic [127:0] x, z, v;
    logic         lsb;
    x = x_q;
    z = z_q;
    v = v_q;
    for (int s = 0; s < 4; s++) begin
      if (x[127]) z = z ^ v;
      lsb = v[0];
      v   = v >> 1;
      if (lsb) v[127:120] = v[127:120] ^ GfPoly;
      x   = x << 1;
    end
    acc_d  = acc_q;
    x_d    = x_q;
    z_d    = z_q;
    v_d    = v_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (busy_q) begin
      x_d   = x;
      z_d   = z;
      v_d   = v;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        acc_d  = z;
      end
    end else if (start_i) begin
      x_d    = acc_q ^ block_i;
      z_d    = '0;
      v_d    = h_i;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end
    if (clear_i) acc_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= 5'd0;
      busy_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    z_q <= z_d;
    v_q <= v_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = busy_q;

endmodule

[rtl/sm4g_back.sv]
module sm4g_back import sm4g_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic       item_valid_i,
  input  sm4g_item_t item_i,
  output logic       item_pop_o,
  output logic       empty,
  input  logic       pop,
  output sm4g_out_t  out_data_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_KEXP = 6'b000010,
    S_HGEN = 6'b000100,
    S_SM4  = 6'b001000,
    S_POST = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e       st_q, st_d;
  logic [4:0]   rnd_q, rnd_d;
  logic [127:0] x_q, x_d;
  logic [31:0]  rk_q [Rounds];
  logic         rk_we;
  logic [127:0] h_q, h_d;
  logic         keys_ready_q, keys_ready_d;
  sm4g_item_t   cur_q, cur_d;
  sm4g_out_t    res_q, res_d, out_q, out_d;
  logic         out_valid_q, out_valid_d;
  logic [31:0]  ctr_q, ctr_d;
  logic [63:0]  abits_q, abits_d, tbits_q, tbits_d;
  logic [63:0]  key_high_q, key_low_q, nonce_high_q;
  logic [31:0]  nonce_low_q;
  logic         decrypt_q;
  logic         gh_start, gh_clear, gh_busy;
  logic [127:0] gh_block, gh_acc;
  logic [31:0]  rk_sel, t_word, b_word, l_word, x4;
  logic [127:0] x_next, sm4_out, sm4_next_out, text_res, tag;
  logic         out_wr;

  sm4g_ghash u_ghash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gh_start),
    .block_i (gh_block),
    .h_i     (h_q),
    .clear_i (gh_clear),
    .acc_o   (gh_acc),
    .busy_o  (gh_busy)
  );

  // one SM4 round, shared by key schedule and block cipher
  always_comb begin
    rk_sel = (st_q == S_KEXP) ? ck_word(rnd_q) : rk_q[rnd_q];
    t_word = x_q[95:64] ^ x_q[63:32] ^ x_q[31:0] ^ rk_sel;
    b_word = sub_word(t_word);
    if (st_q == S_KEXP) begin
      l_word = b_word ^ rotl32(b_word, 13) ^ rotl32(b_word, 23);
    end else begin
      l_word = b_word ^ rotl32(b_word, 2) ^ rotl32(b_word, 10) ^ rotl32(b_word, 18)
               ^ rotl32(b_word, 24);
    end
    x4           = x_q[127:96] ^ l_word;
    x_next       = {x_q[95:0], x4};
    sm4_out      = {x_q[31:0], x_q[63:32], x_q[95:64], x_q[127:96]};
    sm4_next_out = {x_next[31:0], x_next[63:32], x_next[95:64], x_next[127:96]};
    text_res     = (cur_q.data ^ sm4_out) & byte_mask(cur_q.nbytes);
    tag          = sm4_out ^ gh_acc;
  end

  assign out_wr = (st_q == S_EMIT) && (!out_valid_q || pop);

  // sequencer
  always_comb begin
    st_d         = st_q;
    rnd_d        = rnd_q;
    x_d          = x_q;
    rk_we        = 1'b0;
    h_d          = h_q;
    keys_ready_d = keys_ready_q;
    cur_d        = cur_q;
    res_d        = res_q;
    ctr_d        = ctr_q;
    abits_d      = abits_q;
    tbits_d      = tbits_q;
    gh_start     = 1'b0;
    gh_clear     = 1'b0;
    gh_block     = '0;
    item_pop_o   = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (item_valid_i && !gh_busy) begin
          rnd_d = 5'd0;
          if (!keys_ready_q) begin
            x_d  = {key_high_q ^ {FK[0], FK[1]}, key_low_q ^ {FK[2], FK[3]}};
            st_d = S_KEXP;
          end else begin
            item_pop_o = 1'b1;
            cur_d      = item_i;
            case (item_i.kind)
              KIND_AAD: begin
                gh_start = 1'b1;
                gh_block = item_i.data;
                abits_d  = abits_q + {56'd0, item_i.nbytes, 3'd0};
              end
              KIND_TEXT: begin
                x_d  = {nonce_high_q, nonce_low_q, ctr_q};
                st_d = S_SM4;
              end
              default: begin
                gh_start = 1'b1;
                gh_block = {abits_q, tbits_q};
                x_d      = {nonce_high_q, nonce_low_q, CtrTag};
                st_d     = S_SM4;
              end
            endcase
          end
        end
      end
      S_KEXP: begin
        x_d   = x_next;
        rk_we = 1'b1;
        rnd_d = rnd_q + 5'd1;
        if (rnd_q == 5'(Rounds - 1)) begin
          x_d  = '0;
          st_d = S_HGEN;
        end
      end
      S_HGEN: begin
        x_d   = x_next;
        rnd_d = rnd_q + 5'd1;
        if (rnd_q == 5'(Rounds - 1)) begin
          h_d          = sm4_next_out;
          keys_ready_d = 1'b1;
          st_d         = S_IDLE;
        end
      end
      S_SM4: begin
        x_d   = x_next;
        rnd_d = rnd_q + 5'd1;
        if (rnd_q == 5'(Rounds - 1)) st_d = S_POST;
      end
      S_POST: begin
        if (cur_q.kind == KIND_TEXT) begin
          res_d    = '{out_high: text_res[127:64], out_low: text_res[63:0],
                       out_bytes: cur_q.nbytes, is_tag: 1'b0, tag_match: 1'b0};
          gh_start = 1'b1;
          gh_block = decrypt_q ? cur_q.data : text_res;
          ctr_d    = ctr_q + 32'd1;
          tbits_d  = tbits_q + {56'd0, cur_q.nbytes, 3'd0};
          st_d     = S_EMIT;
        end else if (!gh_busy) begin
          res_d    = '{out_high: tag[127:64], out_low: tag[63:0], out_bytes: FullBytes,
                       is_tag: 1'b1, tag_match: decrypt_q && (tag == cur_q.data)};
          gh_clear = 1'b1;
          ctr_d    = CtrStart;
          abits_d  = '0;
          tbits_d  = '0;
          st_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_wr) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    // a new key forces a rebuild before the next item, unless it lands while a rebuild is under way
    if (cfg_we_i && (cfg_index_i == CFG_KEY_HIGH || cfg_index_i == CFG_KEY_LOW)) begin
      keys_ready_d = 1'b0;
    end
  end

  // result register toward the output queue side
  always_comb begin
    out_d       = out_wr ? res_q : out_q;
    out_valid_d = out_wr ? 1'b1 : (pop ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      rnd_q        <= 5'd0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
      ctr_q        <= CtrStart;
      abits_q      <= '0;
      tbits_q      <= '0;
      key_high_q   <= '0;
      key_low_q    <= '0;
      nonce_high_q <= '0;
      nonce_low_q  <= '0;
      decrypt_q    <= 1'b0;
    end else begin
      st_q         <= st_d;
      rnd_q        <= rnd_d;
      keys_ready_q <= keys_ready_d;
      out_valid_q  <= out_valid_d;
      ctr_q        <= ctr_d;
      abits_q      <= abits_d;
      tbits_q      <= tbits_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_KEY_HIGH:   key_high_q   <= cfg_data_i;
          CFG_KEY_LOW:    key_low_q    <= cfg_data_i;
          CFG_NONCE_HIGH: nonce_high_q <= cfg_data_i;
          CFG_NONCE_LOW:  nonce_low_q  <= cfg_data_i[31:0];
          CFG_DECRYPT:    decrypt_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers and round key store
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    h_q   <= h_d;
    cur_q <= cur_d;
    res_q <= res_d;
    out_q <= out_d;
    if (rk_we) rk_q[rnd_q] <= x4;
  end

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

endmodule

[rtl/sm4_gcm_authenticated_cipher.sv]
// Channel   | Signals                                      | Beat taken when
// ----------+----------------------------------------------+-------------------
// input     | push, full, in_data_i                        | push && !full
// result    | empty, pop, out_data_o                       | pop && !empty
// config    | cfg_valid_i, cfg_ready_o, cfg_index_i/data_i | valid && ready
//
// AAD block: one GHASH pass at 4 bits a cycle. Text block: 32 SM4 rounds,
// then a GHASH pass on the ciphertext. Finish: the tag cipher and the
// length-block GHASH run side by side. After reset or a key write the
// first item waits while the round keys and then H are built. A two-deep
// input queue and a result register buffer items, so either side can stall
// without at once holding up the other.
module sm4_gcm_authenticated_cipher import sm4g_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  sm4g_in_t    in_data_i,
  output logic        empty,
  input  logic        pop,
  output sm4g_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic       item_valid, item_pop;
  sm4g_item_t item;

  assign cfg_ready_o = 1'b1;

  sm4g_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  sm4g_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .empty        (empty),
    .pop          (pop),
    .out_data_o   (out_data_o)
  );

  // a tag result always carries a full block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.is_tag) |-> (out_data_o.out_bytes == FullBytes))
    else $error("tag result without full byte count");

  // only a tag may report a match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.is_tag) |-> !out_data_o.tag_match)
    else $error("text result flags a tag match");

  // a waiting result holds until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("waiting result changed before pop");

endmodule
